// ===== design/ros_pkg.sv =====
package ros_pkg;

	// Fixed field widths of the item channels
	localparam int VALUE_W    = 64;
	localparam int KIND_W     = 3;
	localparam int PEEK_W     = 6;
	localparam int DEPTH_W    = 7;
	localparam int REP_LEVELS = 4;

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_REPLICATE = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH  = 3'd0,
		K_POP   = 3'd1,
		K_PEEK  = 3'd2,
		K_RUP   = 3'd3,
		K_RDN   = 3'd4,
		K_CLEAR = 3'd5
	} kind_t;

	// Whole-stack action issued by the controller
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PUSH,
		ACT_POP,
		ACT_POPDUP,
		ACT_RUP,
		ACT_RDN
	} act_t;

	// Per-cell entry move
	typedef enum logic [1:0] {
		MV_HOLD,
		MV_DOWN,
		MV_UP,
		MV_WRAP
	} entry_mv_t;

	// Per-cell read lane move
	typedef enum logic [1:0] {
		LANE_HOLD,
		LANE_LOAD,
		LANE_SHIFT
	} lane_mv_t;

	typedef struct packed {
		act_t     act;
		lane_mv_t lane;
	} stack_cmd_t;

	typedef struct packed {
		entry_mv_t entry;
		lane_mv_t  lane;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SEEK = 2'b10
	} state_t;

endpackage

// ===== design/ros_if.sv =====
interface ros_cmd_if;
	import ros_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [VALUE_W-1:0]  push_value;
	logic [PEEK_W-1:0]   peek_index;

	modport source (output valid, kind, push_value, peek_index, input ready);
	modport sink   (input valid, kind, push_value, peek_index, output ready);
endinterface

interface ros_rsp_if;
	import ros_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  read_value;
	logic [DEPTH_W-1:0]  depth_after;
	logic                was_empty;
	logic                overflowed;

	modport source (output valid, read_value, depth_after, was_empty, overflowed, input ready);
	modport sink   (input valid, read_value, depth_after, was_empty, overflowed, output ready);
endinterface

// ===== design/rpn_operand_stack_core.sv =====
// Calculator operand stack of WORD_BITS-bit words, STACK_DEPTH entries deep.
// cmd channel (valid/ready): kind, push_value, peek_index. One transaction is
// one operation: push, pop, peek, roll up, roll down or clear.
// rsp channel (valid/ready): read_value, depth_after, was_empty, overflowed;
// exactly one response transaction per command, in order.
// The stack is a row of cells, top at cell 0. Push and pop shift the cells one
// place, roll up wraps the top to the bottom cell; those commands, clear and
// short peeks are answered in the cycle after acceptance, and a new command is
// taken every cycle while the receiver takes each response. Peeks at depth k > 0
// and roll downs fetch the word via a read lane that slides one cell a cycle.
// The response register frees the command side: a new command is taken while
// a response waits, provided the receiver takes it in the same cycle;
// while the receiver stalls a held response, cmd.ready stays low.
// Reset (arst_n low) empties the stack and clears replicate_mode; stored words
// are not cleared. The APB port writes replicate_mode at word address 0; the
// user must do so only while no command is outstanding (block does not enforce it).
module rpn_operand_stack_core #(
	parameter int STACK_DEPTH = 64,
	parameter int WORD_BITS   = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ros_cmd_if.sink                         cmd,
	ros_rsp_if.source                       rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ros_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ros_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ros_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import ros_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic                 replicate_mode;
	stack_cmd_t           stk;
	logic [WORD_BITS-1:0] top_word;
	logic [CNT_W-1:0]     count;
	logic [WORD_BITS-1:0] entry_w [STACK_DEPTH];
	logic [WORD_BITS-1:0] lane_w  [STACK_DEPTH];

	ros_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.replicate_mode (replicate_mode)
	);

	ros_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.WORD_BITS   (WORD_BITS),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.replicate_mode (replicate_mode),
		.cmd            (cmd),
		.rsp            (rsp),
		.top_entry      (entry_w[0]),
		.lane_head      (lane_w[0]),
		.stk            (stk),
		.top_word       (top_word),
		.count          (count)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		cell_ctl_t            ctl;
		logic [WORD_BITS-1:0] up_in;
		logic [WORD_BITS-1:0] dn_in;
		logic [WORD_BITS-1:0] lane_dn;
		logic                 is_bottom;

		assign is_bottom = (count == CNT_W'(i + 1));

		if (i == 0) begin : g_top
			assign up_in = top_word;
		end else begin : g_mid
			assign up_in = entry_w[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign dn_in   = entry_w[i];
			assign lane_dn = lane_w[i];
		end else begin : g_inner
			assign dn_in   = entry_w[i+1];
			assign lane_dn = lane_w[i+1];
		end

		always_comb begin
			ctl.lane = stk.lane;
			unique case (stk.act)
				ACT_PUSH, ACT_RDN: ctl.entry = MV_DOWN;
				ACT_POP:           ctl.entry = MV_UP;
				// hold the bottom of the four levels so it is duplicated
				ACT_POPDUP:        ctl.entry = (i == REP_LEVELS - 1) ? MV_HOLD : MV_UP;
				ACT_RUP:           ctl.entry = is_bottom ? MV_WRAP : MV_UP;
				default:           ctl.entry = MV_HOLD;
			endcase
		end

		ros_cell #(
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.up_in   (up_in),
			.dn_in   (dn_in),
			.wrap_in (entry_w[0]),
			.lane_dn (lane_dn),
			.entry   (entry_w[i]),
			.lane    (lane_w[i])
		);
	end

endmodule

// ===== design/ros_cell.sv =====
module ros_cell #(
	parameter int WORD_BITS = 64
) (
	input  logic                  clk,
	input  ros_pkg::cell_ctl_t    ctl,
	input  logic [WORD_BITS-1:0]  up_in,
	input  logic [WORD_BITS-1:0]  dn_in,
	input  logic [WORD_BITS-1:0]  wrap_in,
	input  logic [WORD_BITS-1:0]  lane_dn,
	output logic [WORD_BITS-1:0]  entry,
	output logic [WORD_BITS-1:0]  lane
);
	import ros_pkg::*;

	logic [WORD_BITS-1:0] entry_q;
	logic [WORD_BITS-1:0] lane_q;

	always_ff @(posedge clk) begin
		unique case (ctl.entry)
			MV_HOLD: entry_q <= entry_q;
			MV_DOWN: entry_q <= up_in;
			MV_UP:   entry_q <= dn_in;
			MV_WRAP: entry_q <= wrap_in;
			default: entry_q <= entry_q;
		endcase
	end

	// Read lane: snapshot the entry, then slide toward the top one cell a cycle
	always_ff @(posedge clk) begin
		unique case (ctl.lane)
			LANE_LOAD:  lane_q <= entry_q;
			LANE_SHIFT: lane_q <= lane_dn;
			default:    lane_q <= lane_q;
		endcase
	end

	assign entry = entry_q;
	assign lane  = lane_q;

endmodule

// ===== design/ros_cfg.sv =====
module ros_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ros_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ros_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ros_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output logic                                replicate_mode
);
	import ros_pkg::*;

	logic                 rep_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 hit;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign hit     = (reg_idx == REG_REPLICATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= 1'b0;
		end else if (psel && penable && pwrite && hit) begin
			rep_q <= pwdata[0];
		end
	end

	assign prdata         = hit ? APB_DATA_W'(rep_q) : '0;
	assign pready         = 1'b1;
	assign replicate_mode = rep_q;

endmodule

// ===== design/ros_ctrl.sv =====
module ros_ctrl #(
	parameter int STACK_DEPTH = 64,
	parameter int WORD_BITS   = 64,
	parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  replicate_mode,
	ros_cmd_if.sink               cmd,
	ros_rsp_if.source             rsp,
	input  logic [WORD_BITS-1:0]  top_entry,
	input  logic [WORD_BITS-1:0]  lane_head,
	output ros_pkg::stack_cmd_t   stk,
	output logic [WORD_BITS-1:0]  top_word,
	output logic [CNT_W-1:0]      count
);
	import ros_pkg::*;

	localparam int SEEK_W = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam int CMP_W  = (CNT_W > PEEK_W) ? CNT_W : PEEK_W;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [SEEK_W-1:0]   seek_q, seek_d;
	logic                roll_q, roll_d;

	logic                rsp_valid_q;
	logic [VALUE_W-1:0]  rd_q, rd_d;
	logic [DEPTH_W-1:0]  depth_q;
	logic                empty_q, empty_d;
	logic                ovf_q, ovf_d;

	logic                rsp_free;
	logic                accept;
	logic                load;
	logic [CNT_W-1:0]    grown;
	logic [CMP_W-1:0]    peek_ext;
	logic [CMP_W-1:0]    count_ext;

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && rsp_free;
	assign accept    = cmd.valid && cmd.ready;
	assign peek_ext  = CMP_W'(cmd.peek_index);
	assign count_ext = CMP_W'(count_q);

	always_comb begin
		stk      = '{act: ACT_NONE, lane: LANE_HOLD};
		top_word = cmd.push_value[WORD_BITS-1:0];
		state_d  = state_q;
		count_d  = count_q;
		seek_d   = seek_q;
		roll_d   = roll_q;
		load     = 1'b0;
		rd_d     = '0;
		empty_d  = 1'b0;
		ovf_d    = 1'b0;
		grown    = count_q + CNT_W'(1);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					unique case (kind_t'(cmd.kind))
						K_PUSH: begin
							stk.act = ACT_PUSH;
							if (count_q == CNT_W'(STACK_DEPTH)) begin
								ovf_d = 1'b1;
								grown = count_q;
							end
							count_d = grown;
							if (replicate_mode && grown > CNT_W'(REP_LEVELS))
								count_d = CNT_W'(REP_LEVELS);
						end
						K_POP: begin
							if (count_q == '0) begin
								empty_d = 1'b1;
							end else begin
								rd_d = VALUE_W'(top_entry);
								// Four-level mode: duplicate the bottom, depth stays
								if (replicate_mode && count_q == CNT_W'(REP_LEVELS)) begin
									stk.act = ACT_POPDUP;
								end else begin
									stk.act = ACT_POP;
									count_d = count_q - CNT_W'(1);
								end
							end
						end
						K_PEEK: begin
							if (peek_ext < count_ext) begin
								if (cmd.peek_index == '0) begin
									rd_d = VALUE_W'(top_entry);
								end else begin
									load      = 1'b0;
									state_d   = S_SEEK;
									seek_d    = SEEK_W'(cmd.peek_index);
									roll_d    = 1'b0;
									stk.lane  = LANE_LOAD;
								end
							end else begin
								empty_d = 1'b1;
							end
						end
						K_RUP: begin
							if (count_q != '0)
								stk.act = ACT_RUP;
						end
						K_RDN: begin
							// A single entry is its own bottom: nothing moves
							if (count_q > CNT_W'(1)) begin
								load     = 1'b0;
								state_d  = S_SEEK;
								seek_d   = SEEK_W'(count_q - CNT_W'(1));
								roll_d   = 1'b1;
								stk.lane = LANE_LOAD;
							end
						end
						K_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_SEEK: begin
				if (seek_q != '0) begin
					stk.lane = LANE_SHIFT;
					seek_d   = seek_q - SEEK_W'(1);
				end else if (rsp_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					if (roll_q) begin
						stk.act  = ACT_RDN;
						top_word = lane_head;
					end else begin
						rd_d = VALUE_W'(lane_head);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			seek_q      <= '0;
			roll_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			seek_q  <= seek_d;
			roll_q  <= roll_d;
			if (load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rd_q    <= rd_d;
			depth_q <= DEPTH_W'(count_d);
			empty_q <= empty_d;
			ovf_q   <= ovf_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = rd_q;
	assign rsp.depth_after = depth_q;
	assign rsp.was_empty   = empty_q;
	assign rsp.overflowed  = ovf_q;
	assign count           = count_q;

endmodule
